[src/tpg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Test pattern generator package
// Payload, configuration and classification types, pattern constants and
// small helper functions shared by the generator modules.
// ----------------------------------------------------------------------------
package tpg_pkg;

   localparam int COORD_BITS = 12;
   localparam int ADDR_BITS  = 2 * COORD_BITS;
   localparam int COLOR_BITS = 16;
   // Frame height over ten fits in this many bits
   localparam int BAND_BITS  = COORD_BITS - 3;
   // Signed box offsets and pixel distances from the box corner
   localparam int OFFS_BITS  = COORD_BITS + 2;

   localparam int NUM_BARS       = 8;
   localparam int BAR_INDEX_BITS = 3;
   localparam int CELL_SHIFT     = 5;
   localparam int BOX_W          = 640;
   localparam int BOX_H          = 480;
   localparam int BOX_INSET      = 8;
   localparam int BOX_EDGE       = 4;

   // Height / 10 as (height * 6554) >> 16, exact over the coordinate range
   localparam int BAND_RECIP      = 6554;
   localparam int BAND_RECIP_BITS = 13;
   localparam int BAND_SHIFT      = 16;
   localparam int BAND_PROD_BITS  = COORD_BITS + BAND_RECIP_BITS;

   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_STRIDE  = 2'd2;

   localparam int RESET_WIDTH  = 720;
   localparam int RESET_HEIGHT = 1280;
   localparam int RESET_STRIDE = 720;
   localparam int RESET_BAND   = RESET_HEIGHT / 10;
   localparam int RESET_BOX_X  = (RESET_WIDTH - BOX_W) / 2;
   localparam int RESET_BOX_Y  = (RESET_HEIGHT - BOX_H) / 2;

   localparam logic [COLOR_BITS-1:0] COLOR_EDGE  = 16'hFEE0;
   localparam logic [COLOR_BITS-1:0] COLOR_FILL  = 16'h118C;
   localparam logic [COLOR_BITS-1:0] COLOR_LIGHT = 16'hCE59;
   localparam logic [COLOR_BITS-1:0] COLOR_DARK  = 16'h2945;
   localparam logic [COLOR_BITS-1:0] COLOR_BLACK = 16'h0000;

   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  pixel_inside;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0]       width;
      logic [COORD_BITS-1:0]       height;
      logic [COORD_BITS-1:0]       stride;
      logic [BAND_BITS-1:0]        band;
      logic signed [OFFS_BITS-1:0] box_x;
      logic signed [OFFS_BITS-1:0] box_y;
   } cfg_type;

   // Classified pixel, queued between the front and back ends
   typedef struct packed {
      logic [ADDR_BITS-1:0]      row_base;
      logic [COORD_BITS-1:0]     pixel_x;
      logic                      in_frame;
      logic                      in_box;
      logic                      box_edge;
      logic                      box_fill;
      logic                      in_bars;
      logic [BAR_INDEX_BITS-1:0] bar_index;
      logic                      parity;
   } tag_type;

   function automatic logic [COLOR_BITS-1:0] bar_color(
      input logic [BAR_INDEX_BITS-1:0] index);
      logic [COLOR_BITS-1:0] color;
      begin
         case (index)
            3'd0:    color = 16'hF800;
            3'd1:    color = 16'hFFE0;
            3'd2:    color = 16'h07E0;
            3'd3:    color = 16'h07FF;
            3'd4:    color = 16'h001F;
            3'd5:    color = 16'hF81F;
            3'd6:    color = 16'hFFFF;
            default: color = 16'h2104;
         endcase
         bar_color = color;
      end
   endfunction

   function automatic logic [BAND_BITS-1:0] band_height(
      input logic [COORD_BITS-1:0] height);
      logic [BAND_PROD_BITS-1:0] prod;
      begin
         prod = BAND_PROD_BITS'(height) * BAND_PROD_BITS'(BAND_RECIP);
         band_height = prod[BAND_SHIFT +: BAND_BITS];
      end
   endfunction

   // (size - span) / 2, truncated toward zero
   function automatic logic signed [OFFS_BITS-1:0] box_offset(
      input logic [COORD_BITS-1:0] size,
      input logic [COORD_BITS-1:0] span);
      logic signed [OFFS_BITS-1:0] diff;
      begin
         diff = $signed(OFFS_BITS'(size)) - $signed(OFFS_BITS'(span));
         if (diff < 0) begin
            box_offset = (diff + $signed(OFFS_BITS'(1))) >>> 1;
         end else begin
            box_offset = diff >>> 1;
         end
      end
   endfunction

endpackage
`default_nettype wire

[src/tpg_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Test pattern generator configuration registers
// Holds frame size and stride, and precomputes band height and box offsets
// from the written data so they are valid the cycle after a write.
// ----------------------------------------------------------------------------
module tpg_csr (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire [tpg_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire [tpg_pkg::COORD_BITS-1:0]           csr_wdata,
   output tpg_pkg::cfg_type                        cfg
);

   tpg_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= tpg_pkg::COORD_BITS'(tpg_pkg::RESET_WIDTH);
         cfg_ff.height <= tpg_pkg::COORD_BITS'(tpg_pkg::RESET_HEIGHT);
         cfg_ff.stride <= tpg_pkg::COORD_BITS'(tpg_pkg::RESET_STRIDE);
         cfg_ff.band   <= tpg_pkg::BAND_BITS'(tpg_pkg::RESET_BAND);
         cfg_ff.box_x  <= tpg_pkg::OFFS_BITS'(tpg_pkg::RESET_BOX_X);
         cfg_ff.box_y  <= tpg_pkg::OFFS_BITS'(tpg_pkg::RESET_BOX_Y);
      end else if (csr_valid) begin
         case (csr_index)
            tpg_pkg::CSR_FRAME_WIDTH: begin
               cfg_ff.width <= csr_wdata;
               cfg_ff.box_x <= tpg_pkg::box_offset(csr_wdata,
                                  tpg_pkg::COORD_BITS'(tpg_pkg::BOX_W));
            end
            tpg_pkg::CSR_FRAME_HEIGHT: begin
               cfg_ff.height <= csr_wdata;
               cfg_ff.band   <= tpg_pkg::band_height(csr_wdata);
               cfg_ff.box_y  <= tpg_pkg::box_offset(csr_wdata,
                                   tpg_pkg::COORD_BITS'(tpg_pkg::BOX_H));
            end
            tpg_pkg::CSR_LINE_STRIDE: begin
               cfg_ff.stride <= csr_wdata;
            end
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

endmodule
`default_nettype wire

[src/tpg_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Test pattern generator front end
// Accepts pixel coordinates and classifies each into pattern layer, bar
// index, checker parity and box region; forms the row base address.
// ----------------------------------------------------------------------------
module tpg_front (
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire tpg_pkg::req_type    req_data,
   input  wire tpg_pkg::cfg_type    cfg,
   input  wire                      queue_full,
   output logic                     push,
   output tpg_pkg::tag_type         tag
);

   logic [tpg_pkg::COORD_BITS-1:0]       px;
   logic [tpg_pkg::COORD_BITS-1:0]       py;
   logic [tpg_pkg::COORD_BITS-1:0]       bars_end;
   logic [tpg_pkg::COORD_BITS-1:0]       band_ext;
   logic [tpg_pkg::COORD_BITS-1:0]       thresh;
   logic [tpg_pkg::COORD_BITS-1:0]       below_bars;
   logic [tpg_pkg::BAR_INDEX_BITS-1:0]   bar_index;
   logic signed [tpg_pkg::OFFS_BITS-1:0] dx;
   logic signed [tpg_pkg::OFFS_BITS-1:0] dy;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   assign px         = req_data.pixel_x;
   assign py         = req_data.pixel_y;
   assign band_ext   = tpg_pkg::COORD_BITS'(cfg.band);
   assign bars_end   = {cfg.band, 3'b000};
   assign below_bars = py - bars_end;

   // Count the band boundaries at or above which the row lies
   always_comb begin
      bar_index = '0;
      thresh    = '0;
      for (int k = 1; k < tpg_pkg::NUM_BARS; k++) begin
         thresh = tpg_pkg::COORD_BITS'(k) * band_ext;
         if (py >= thresh) begin
            bar_index = bar_index + tpg_pkg::BAR_INDEX_BITS'(1);
         end
      end
   end

   assign dx = $signed(tpg_pkg::OFFS_BITS'(px)) - cfg.box_x;
   assign dy = $signed(tpg_pkg::OFFS_BITS'(py)) - cfg.box_y;

   always_comb begin
      tag.row_base  = tpg_pkg::ADDR_BITS'(py) * tpg_pkg::ADDR_BITS'(cfg.stride);
      tag.pixel_x   = px;
      tag.in_frame  = (px < cfg.width) && (py < cfg.height);
      tag.in_box    = (dx >= 0) && (dx < tpg_pkg::BOX_W) &&
                      (dy >= 0) && (dy < tpg_pkg::BOX_H);
      tag.box_edge  = (dy < tpg_pkg::BOX_EDGE) ||
                      (dy >= tpg_pkg::BOX_H - tpg_pkg::BOX_EDGE) ||
                      (dx < tpg_pkg::BOX_EDGE) ||
                      (dx >= tpg_pkg::BOX_W - tpg_pkg::BOX_EDGE);
      tag.box_fill  = (dx >= tpg_pkg::BOX_INSET) &&
                      (dx < tpg_pkg::BOX_W - tpg_pkg::BOX_INSET) &&
                      (dy >= tpg_pkg::BOX_INSET) &&
                      (dy < tpg_pkg::BOX_H - tpg_pkg::BOX_INSET);
      tag.in_bars   = py < bars_end;
      tag.bar_index = bar_index;
      // Cell rows start at the end of the bars
      tag.parity    = px[tpg_pkg::CELL_SHIFT] ^ bars_end[tpg_pkg::CELL_SHIFT] ^
                      below_bars[tpg_pkg::CELL_SHIFT];
   end

endmodule
`default_nettype wire

[src/tpg_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Test pattern generator queue
// Short first-in first-out buffer of classified pixels between the front
// and back ends.
// ----------------------------------------------------------------------------
module tpg_queue #(
   parameter int DEPTH = 4
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      push,
   input  wire tpg_pkg::tag_type    push_data,
   input  wire                      pop,
   output tpg_pkg::tag_type         pop_data,
   output logic                     full,
   output logic                     not_empty
);

   localparam int PTR_BITS   = $clog2(DEPTH);
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   tpg_pkg::tag_type       slots_ff [DEPTH];
   logic [PTR_BITS-1:0]    wr_ptr_ff;
   logic [PTR_BITS-1:0]    wr_ptr_in;
   logic [PTR_BITS-1:0]    rd_ptr_ff;
   logic [PTR_BITS-1:0]    rd_ptr_in;
   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;

   assign full      = (count_ff == COUNT_BITS'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[src/tpg_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Test pattern generator back end
// Resolves the layered color, completes the word address and holds the
// result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module tpg_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      not_empty,
   input  wire tpg_pkg::tag_type    tag,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output tpg_pkg::rsp_type         rsp_data
);

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   tpg_pkg::rsp_type                  rsp_data_ff;
   tpg_pkg::rsp_type                  rsp_data_in;
   logic [tpg_pkg::COLOR_BITS-1:0]    color;

   // Refill the output register when it is empty or being taken
   assign pop          = not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);

   always_comb begin
      if (!tag.in_frame) begin
         color = tpg_pkg::COLOR_BLACK;
      end else if (tag.in_box) begin
         if (tag.box_edge) begin
            color = tpg_pkg::COLOR_EDGE;
         end else if (tag.box_fill) begin
            color = tpg_pkg::COLOR_FILL;
         end else begin
            color = tpg_pkg::COLOR_BLACK;
         end
      end else if (tag.in_bars) begin
         color = tpg_pkg::bar_color(tag.bar_index);
      end else if (tag.parity) begin
         color = tpg_pkg::COLOR_LIGHT;
      end else begin
         color = tpg_pkg::COLOR_DARK;
      end
   end

   always_comb begin
      rsp_data_in.pixel_address = tag.row_base + tpg_pkg::ADDR_BITS'(tag.pixel_x);
      rsp_data_in.pixel_color   = color;
      rsp_data_in.pixel_inside  = tag.in_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[src/display_test_pattern_generator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// An accepted transaction is queued, then popped into the rsp_valid output register.
// Throughput: one pixel per cycle while rsp_stall is low, set by the classify and
//   resolve stages and the QUEUE_DEPTH-entry queue between them.
// Reset: synchronous; empties the queue and output register and loads the
//   720x1280 frame with stride 720. Register writes take effect next cycle.
// ----------------------------------------------------------------------------
// Display test pattern generator
// Gives the framebuffer word address and RGB565 color of each pixel under a
// color bar, checkerboard and centered box pattern.
// ----------------------------------------------------------------------------
module display_test_pattern_generator_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire tpg_pkg::req_type               req_data,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output tpg_pkg::rsp_type                    rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [tpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [tpg_pkg::COORD_BITS-1:0]       csr_wdata
);

   tpg_pkg::cfg_type  cfg;
   tpg_pkg::tag_type  push_tag;
   tpg_pkg::tag_type  head_tag;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_not_empty;

   tpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tpg_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .tag        (push_tag)
   );

   tpg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_tag),
      .pop       (pop),
      .pop_data  (head_tag),
      .full      (queue_full),
      .not_empty (queue_not_empty)
   );

   tpg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (queue_not_empty),
      .tag       (head_tag),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

[src/tpg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Test pattern generator port checker
// Watches the top-level ports for output protocol, progress and color rules.
// ----------------------------------------------------------------------------
module tpg_checker (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   input  wire                                 req_stall,
   input  wire                                 rsp_valid,
   input  wire                                 rsp_stall,
   input  wire tpg_pkg::rsp_type               rsp_data
);

   // Output register is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed or dropped");

   // Pixels outside the frame are black
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.pixel_inside) |-> (rsp_data.pixel_color == '0))
      else $error("nonzero color outside the frame");

   // An accepted transaction reaches the output once the output moves
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("accepted pixel did not reach the output");

endmodule

bind display_test_pattern_generator_top tpg_checker u_tpg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire

[dv/display_test_pattern_generator_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display test pattern generator testbench
// Feeds pixel coordinates through the request channel and checks every
// address, color and inside flag against a behavioral pattern predictor or
// typed expected values. A directed table covers extremes and corner cases
// of the pattern, and random phases then sweep several frame geometries
// under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module display_test_pattern_generator_top_tb;

   localparam int CLOCK_HALF    = 4;
   localparam int COORD_MAX     = (1 << tpg_pkg::COORD_BITS) - 1;
   localparam int BOX_COLS      = 640;
   localparam int BOX_ROWS      = 480;
   localparam int BOX_BORDER    = 4;
   localparam int BOX_MARGIN    = 8;
   localparam int CHECKER_CELL  = 32;
   localparam int BAND_SPLIT    = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_PIXELS  = 180;

   typedef enum logic {ROW_PIXEL, ROW_FRAME} row_kind_type;

   // Pixel rows use a and b as column and row; frame rows use a, b, c as
   // width, height and stride
   typedef struct packed {
      row_kind_type                   kind;
      logic [tpg_pkg::COORD_BITS-1:0] a;
      logic [tpg_pkg::COORD_BITS-1:0] b;
      logic [tpg_pkg::COORD_BITS-1:0] c;
      logic                           typed;
      tpg_pkg::rsp_type               want;
   } row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   tpg_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   tpg_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [tpg_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [tpg_pkg::COORD_BITS-1:0]     csr_wdata;

   int cfg_width;
   int cfg_height;
   int cfg_stride;

   tpg_pkg::rsp_type pending_pixels [$];
   tpg_pkg::rsp_type head_pixel;
   int      mismatch_count;
   int      send_idle_pct;
   int      stall_pct;
   int      hold_requests;
   int      idle_cycles;

   display_test_pattern_generator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // ------------------------------------------------------------------------
   // Pattern predictor
   // ------------------------------------------------------------------------
   function automatic logic [tpg_pkg::COLOR_BITS-1:0] rgb565(input int r, input int g,
                                                            input int b);
      return tpg_pkg::COLOR_BITS'(((r & 'hF8) << 8) | ((g & 'hFC) << 3) | ((b & 'hF8) >> 3));
   endfunction

   function automatic logic [tpg_pkg::COLOR_BITS-1:0] bar_shade(input int index);
      case (index)
         0:       return rgb565(255, 0, 0);
         1:       return rgb565(255, 255, 0);
         2:       return rgb565(0, 255, 0);
         3:       return rgb565(0, 255, 255);
         4:       return rgb565(0, 0, 255);
         5:       return rgb565(255, 0, 255);
         6:       return rgb565(255, 255, 255);
         default: return rgb565(32, 32, 32);
      endcase
   endfunction

   function automatic bit in_run(input int v, input int lo, input int len);
      return (v >= lo) && (v < lo + len);
   endfunction

   function automatic tpg_pkg::rsp_type predict_pixel(input tpg_pkg::req_type px);
      tpg_pkg::rsp_type r;
      int      x;
      int      y;
      int      band;
      int      bars_end;
      int      cell_row;
      int      gx;
      int      gy;
      bit      border_hit;
      x = px.pixel_x;
      y = px.pixel_y;
      r.pixel_address = tpg_pkg::ADDR_BITS'(y * cfg_stride + x);
      r.pixel_inside  = (x < cfg_width) && (y < cfg_height);
      r.pixel_color   = '0;
      if (r.pixel_inside) begin
         band     = cfg_height / BAND_SPLIT;
         bars_end = band * 8;
         if (y < bars_end) begin
            r.pixel_color = bar_shade((y / band) % 8);
         end else begin
            // checker rows restart where the bars end
            cell_row = bars_end + ((y - bars_end) / CHECKER_CELL) * CHECKER_CELL;
            r.pixel_color = ((x / CHECKER_CELL + cell_row / CHECKER_CELL) % 2 != 0) ?
                            rgb565(200, 200, 200) : rgb565(40, 40, 40);
         end
         // signed division truncates toward zero, as the box offset needs
         gx = (cfg_width - BOX_COLS) / 2;
         gy = (cfg_height - BOX_ROWS) / 2;
         if (in_run(x, gx, BOX_COLS) && in_run(y, gy, BOX_ROWS)) begin
            border_hit = in_run(y, gy, BOX_BORDER) ||
                         in_run(y, gy + BOX_ROWS - BOX_BORDER, BOX_BORDER) ||
                         in_run(x, gx, BOX_BORDER) ||
                         in_run(x, gx + BOX_COLS - BOX_BORDER, BOX_BORDER);
            if (border_hit)
               r.pixel_color = rgb565(255, 220, 0);
            else if (in_run(x, gx + BOX_MARGIN, BOX_COLS - 2 * BOX_MARGIN) &&
                     in_run(y, gy + BOX_MARGIN, BOX_ROWS - 2 * BOX_MARGIN))
               r.pixel_color = rgb565(16, 48, 96);
            else
               r.pixel_color = rgb565(0, 0, 0);
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [tpg_pkg::COORD_BITS-1:0] clamp_coord(input int v);
      if (v < 0)
         return '0;
      if (v > COORD_MAX)
         return tpg_pkg::COORD_BITS'(COORD_MAX);
      return tpg_pkg::COORD_BITS'(v);
   endfunction

   function automatic row_type pixel_row(input int x, input int y);
      row_type row;
      row       = '0;
      row.kind  = ROW_PIXEL;
      row.a     = tpg_pkg::COORD_BITS'(x);
      row.b     = tpg_pkg::COORD_BITS'(y);
      return row;
   endfunction

   function automatic row_type checked_row(input int x, input int y, input int address,
                                           input int color, input bit inside_flag);
      row_type row;
      row                    = pixel_row(x, y);
      row.typed              = 1'b1;
      row.want.pixel_address = tpg_pkg::ADDR_BITS'(address);
      row.want.pixel_color   = tpg_pkg::COLOR_BITS'(color);
      row.want.pixel_inside  = inside_flag;
      return row;
   endfunction

   function automatic row_type frame_row(input int w, input int h, input int stride);
      row_type row;
      row      = '0;
      row.kind = ROW_FRAME;
      row.a    = tpg_pkg::COORD_BITS'(w);
      row.b    = tpg_pkg::COORD_BITS'(h);
      row.c    = tpg_pkg::COORD_BITS'(stride);
      return row;
   endfunction

   // Mostly coordinates that land in the pattern, plus box edges, band
   // boundaries and the whole coordinate range
   function automatic tpg_pkg::req_type random_pixel();
      tpg_pkg::req_type px;
      int      pick;
      int      gx;
      int      gy;
      int      band;
      int      jitter;
      int      anchors [6];
      anchors = '{0, BOX_BORDER, BOX_MARGIN, BOX_COLS - BOX_MARGIN,
                  BOX_COLS - BOX_BORDER, BOX_COLS};
      gx      = (cfg_width - BOX_COLS) / 2;
      gy      = (cfg_height - BOX_ROWS) / 2;
      band    = cfg_height / BAND_SPLIT;
      jitter  = int'($urandom_range(4)) - 2;
      pick    = $urandom_range(99);
      px.pixel_x = tpg_pkg::COORD_BITS'($urandom);
      px.pixel_y = tpg_pkg::COORD_BITS'($urandom);
      if (pick < 50) begin
         if (cfg_width > 0)
            px.pixel_x = tpg_pkg::COORD_BITS'($urandom_range(cfg_width - 1));
         if (cfg_height > 0)
            px.pixel_y = tpg_pkg::COORD_BITS'($urandom_range(cfg_height - 1));
      end else if (pick < 70) begin
         if ($urandom_range(1) == 0) begin
            px.pixel_x = clamp_coord(gx + anchors[$urandom_range(5)] + jitter);
            px.pixel_y = clamp_coord(gy + int'($urandom_range(BOX_ROWS - 1)));
         end else begin
            px.pixel_x = clamp_coord(gx + int'($urandom_range(BOX_COLS - 1)));
            px.pixel_y = clamp_coord(gy + anchors[$urandom_range(5)] * BOX_ROWS / BOX_COLS
                                     + jitter);
         end
      end else if (pick < 80) begin
         if (cfg_width > 0)
            px.pixel_x = tpg_pkg::COORD_BITS'($urandom_range(cfg_width - 1));
         px.pixel_y = clamp_coord(band * int'($urandom_range(8)) + jitter);
      end
      return px;
   endfunction

   task automatic drive_pixel(input tpg_pkg::req_type px, input bit typed,
                              input tpg_pkg::rsp_type want);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      pending_pixels.push_back(typed ? want : predict_pixel(px));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic load_frame(input int w, input int h, input int stride);
      logic [tpg_pkg::CSR_INDEX_BITS-1:0] regs [3];
      int                                 values [3];
      regs   = '{tpg_pkg::CSR_FRAME_WIDTH, tpg_pkg::CSR_FRAME_HEIGHT,
                 tpg_pkg::CSR_LINE_STRIDE};
      values = '{w, h, stride};
      wait_drained();
      for (int i = 0; i < 3; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= tpg_pkg::COORD_BITS'(values[i]);
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid  <= 1'b0;
      cfg_width  = w & COORD_MAX;
      cfg_height = h & COORD_MAX;
      cfg_stride = stride & COORD_MAX;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected transaction", longint'(rsp_data), longint'(0));
         end else begin
            head_pixel = pending_pixels.pop_front();
            if (rsp_data.pixel_address !== head_pixel.pixel_address)
               report_mismatch("pixel_address", longint'(rsp_data.pixel_address),
                               longint'(head_pixel.pixel_address));
            if (rsp_data.pixel_color !== head_pixel.pixel_color)
               report_mismatch("pixel_color", longint'(rsp_data.pixel_color),
                               longint'(head_pixel.pixel_color));
            if (rsp_data.pixel_inside !== head_pixel.pixel_inside)
               report_mismatch("pixel_inside", longint'(rsp_data.pixel_inside),
                               longint'(head_pixel.pixel_inside));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output stall: random, or a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: cycles without any transaction on any channel
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      row_type directed [$];
      row_type row;
      tpg_pkg::req_type px;
      int      w;
      int      h;
      int      stride;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_index      = tpg_pkg::CSR_FRAME_WIDTH;
      csr_wdata      = '0;
      cfg_width      = 720;
      cfg_height     = 1280;
      cfg_stride     = 720;
      mismatch_count = 0;
      send_idle_pct  = 0;
      stall_pct      = 0;
      hold_requests  = 0;

      directed = '{
         // frame after reset: 720x1280, stride 720, 128-row bands
         checked_row(0, 0, 0, 16'hF800, 1'b1),
         checked_row(4095, 4095, 2952495, 0, 1'b0),
         checked_row(720, 0, 720, 0, 1'b0),
         checked_row(0, 1280, 921600, 0, 1'b0),
         checked_row(0, 128, 92160, 16'hFFE0, 1'b1),
         checked_row(0, 896, 645120, 16'h2104, 1'b1),
         pixel_row(40, 400),
         pixel_row(48, 408),
         pixel_row(44, 404),
         pixel_row(679, 879),
         pixel_row(719, 1279),
         pixel_row(2730, 1365),
         // zero width: nothing inside
         frame_row(0, 1280, 720),
         checked_row(0, 0, 0, 0, 1'b0),
         // short frame without bars, zero stride
         frame_row(4095, 9, 0),
         pixel_row(100, 5),
         checked_row(4095, 8, 4095, 0, 1'b0),
         pixel_row(4094, 8),
         pixel_row(1727, 0),
         // one-pixel frame, box clipped on all sides
         frame_row(1, 1, 4095),
         pixel_row(0, 0),
         checked_row(0, 4095, 16769025, 0, 1'b0),
         checked_row(4095, 4095, 16773120, 0, 1'b0),
         // box exactly fills the frame
         frame_row(640, 480, 640),
         pixel_row(0, 0),
         pixel_row(639, 479),
         pixel_row(320, 240)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         if (row.kind == ROW_FRAME) begin
            load_frame(row.a, row.b, row.c);
         end else begin
            px.pixel_x = row.a;
            px.pixel_y = row.b;
            drive_pixel(px, row.typed, row.want);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin w = 720;  h = 1280; stride = 720;  end
            1: begin w = 4095; h = 4095; stride = 4095; end
            2: begin w = 1;    h = 1;    stride = 1;    end
            3: begin w = 1920; h = 1080; stride = 1920; end
            4: begin w = 640;  h = 480;  stride = 640;  end
            5: begin
               w      = $urandom_range(1, COORD_MAX);
               h      = $urandom_range(1, COORD_MAX);
               stride = $urandom_range(COORD_MAX);
            end
            6: begin w = 300;  h = 9;    stride = 0;    end
            default: begin
               w      = $urandom_range(100, 1000);
               h      = $urandom_range(10, 200);
               stride = w + $urandom_range(64);
            end
         endcase
         load_frame(w, h, stride);
         case (p % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 49; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 49; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         // hold the output while requests keep coming, so the queue backs up
         if (p == 0)
            hold_requests++;
         for (int n = 0; n < PHASE_PIXELS; n++)
            drive_pixel(random_pixel(), 1'b0, '0);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[files.f]
src/tpg_pkg.sv
src/tpg_csr.sv
src/tpg_front.sv
src/tpg_queue.sv
src/tpg_back.sv
src/display_test_pattern_generator_top.sv
src/tpg_checker.sv
dv/display_test_pattern_generator_top_tb.sv
